@@ hw/rtl/lpfg_pkg.sv @@
// Shared constants, types and the arctangent table for the LOS guidance pipeline.
// No dependencies; lpfg_front, lpfg_cordic, lpfg_gain and the top level import this package.
package lpfg_pkg;

  localparam int CORDIC_STAGES = 16;
  // Stage counts beyond the table length act as the full table.
  localparam int NSTAGE = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;

  // Datapath width inside the CORDIC: 33-bit differences, 8 guard bits, gain and headroom.
  localparam int CW = 46;
  localparam int GUARD_BITS = 8;
  // Product of a CORDIC lane by the inverse gain.
  localparam int PW = CW + 21;

  localparam logic signed [20:0] INV_GAIN = 21'sd636751;
  localparam logic [31:0] ANGLE_90  = 32'h4000_0000;
  localparam logic [31:0] ANGLE_270 = 32'hC000_0000;
  localparam logic [23:0] LOOKAHEAD_RESET = 24'd20480;

  typedef logic signed [CW-1:0] cvec_t;

  typedef struct packed {
    logic               degenerate;
    logic [31:0]        gamma;
    logic signed [31:0] xte;
  } side_t;

  typedef struct packed {
    cvec_t       x;
    cvec_t       y;
    cvec_t       u;
    cvec_t       v;
    logic [31:0] z;
    side_t       side;
  } cstate_t;

  function automatic logic [31:0] atan_entry(input logic [4:0] idx);
    logic [31:0] a;
    unique case (idx)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2F9;
      5'd15: a = 32'h0000517C;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A2F;
      5'd19: a = 32'h00000517;
      5'd20: a = 32'h0000028B;
      5'd21: a = 32'h00000145;
      5'd22: a = 32'h000000A2;
      5'd23: a = 32'h00000051;
      5'd24: a = 32'h00000028;
      5'd25: a = 32'h00000014;
      5'd26: a = 32'h0000000A;
      5'd27: a = 32'h00000005;
      5'd28: a = 32'h00000002;
      5'd29: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

  // 32-bit binary angle rounded half up to 16 bits, wrapping.
  function automatic logic [15:0] angle16(input logic [31:0] a);
    logic [31:0] r;
    r = a + 32'h0000_8000;
    return r[31:16];
  endfunction

endpackage

@@ hw/rtl/lpfg_if.sv @@
// Valid/ready channel interfaces for guidance queries and guidance results.
// Stand-alone; used by the top level and the front stage.
interface lpfg_query_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic signed [31:0] end_x;
  logic signed [31:0] end_y;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  modport source (output valid, start_x, start_y, end_x, end_y, pos_x, pos_y, input ready);
  modport sink (input valid, start_x, start_y, end_x, end_y, pos_x, pos_y, output ready);
endinterface

interface lpfg_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] course_command;
  logic signed [15:0] path_angle;
  logic signed [31:0] cross_track_error;
  logic               degenerate;
  modport source (output valid, course_command, path_angle, cross_track_error, degenerate,
                  input ready);
  modport sink (input valid, course_command, path_angle, cross_track_error, degenerate,
                output ready);
endinterface

@@ hw/rtl/lpfg_front.sv @@
// Input register stage: segment direction, start-to-position offset, zero-length flag.
// Depends on lpfg_pkg and lpfg_query_if.
module lpfg_front (
  input  logic            clk,
  input  logic            rst,
  lpfg_query_if.sink      query,
  output logic            out_valid,
  input  logic            out_ready,
  output lpfg_pkg::cstate_t out_data
);
  import lpfg_pkg::*;

  logic               en;
  logic signed [32:0] dx, dy, wx, wy;
  cstate_t            data_next;

  assign en = !out_valid || out_ready;
  assign query.ready = en;

  always_comb begin
    dx = {query.end_x[31], query.end_x} - {query.start_x[31], query.start_x};
    dy = {query.end_y[31], query.end_y} - {query.start_y[31], query.start_y};
    wx = {query.start_x[31], query.start_x} - {query.pos_x[31], query.pos_x};
    wy = {query.start_y[31], query.start_y} - {query.pos_y[31], query.pos_y};
    data_next.x = CW'($signed({dx, 8'h00}));
    data_next.y = CW'($signed({dy, 8'h00}));
    data_next.u = CW'($signed({wx, 8'h00}));
    data_next.v = CW'($signed({wy, 8'h00}));
    data_next.z = '0;
    data_next.side.degenerate = (dx == '0) && (dy == '0);
    data_next.side.gamma = '0;
    data_next.side.xte = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= query.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= data_next;
    end
  end
endmodule

@@ hw/rtl/lpfg_cordic.sv @@
// Pipelined vectoring CORDIC: one quadrant stage, then one register stage per micro-rotation.
// The (u,v) pair is rotated alongside; side data rides along. Depends on lpfg_pkg.
module lpfg_cordic (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  lpfg_pkg::cstate_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output lpfg_pkg::cstate_t out_data
);
  import lpfg_pkg::*;

  cstate_t st  [NSTAGE+1];
  logic    vld [NSTAGE+1];
  logic    en  [NSTAGE+1];
  cstate_t pre;

  // A stage loads when it is empty or its content moves on.
  always_comb begin
    en[NSTAGE] = !vld[NSTAGE] || out_ready;
    for (int k = NSTAGE - 1; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[NSTAGE];
  assign out_data  = st[NSTAGE];

  // Bring a left-half vector into the right half by a quarter turn.
  always_comb begin
    pre = in_data;
    pre.z = '0;
    if (in_data.x < 0) begin
      if (in_data.y >= 0) begin
        pre.x = in_data.y;
        pre.y = -in_data.x;
        pre.u = in_data.v;
        pre.v = -in_data.u;
        pre.z = ANGLE_90;
      end else begin
        pre.x = -in_data.y;
        pre.y = in_data.x;
        pre.u = -in_data.v;
        pre.v = in_data.u;
        pre.z = ANGLE_270;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en[0]) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      st[0] <= pre;
    end
  end

  for (genvar k = 1; k <= NSTAGE; k++) begin : g_rot
    localparam int SH = k - 1;
    cstate_t rot;

    always_comb begin
      rot = st[k-1];
      if (st[k-1].y >= 0) begin
        rot.x = st[k-1].x + (st[k-1].y >>> SH);
        rot.y = st[k-1].y - (st[k-1].x >>> SH);
        rot.u = st[k-1].u + (st[k-1].v >>> SH);
        rot.v = st[k-1].v - (st[k-1].u >>> SH);
        rot.z = st[k-1].z + atan_entry(5'(SH));
      end else begin
        rot.x = st[k-1].x - (st[k-1].y >>> SH);
        rot.y = st[k-1].y + (st[k-1].x >>> SH);
        rot.u = st[k-1].u - (st[k-1].v >>> SH);
        rot.v = st[k-1].v + (st[k-1].u >>> SH);
        rot.z = st[k-1].z - atan_entry(5'(SH));
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en[k]) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        st[k] <= rot;
      end
    end
  end
endmodule

@@ hw/rtl/lpfg_gain.sv @@
// Gain correction of the rotated offset into the cross-track error, then setup of the
// steering arctangent vector. Two register stages. Depends on lpfg_pkg.
module lpfg_gain (
  input  logic              clk,
  input  logic              rst,
  input  logic [23:0]       lookahead,
  input  logic              in_valid,
  output logic              in_ready,
  input  lpfg_pkg::cstate_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output lpfg_pkg::cstate_t out_data
);
  import lpfg_pkg::*;

  localparam logic signed [PW-1:0] RND  = PW'(64'sd1 <<< (GUARD_BITS + 19));
  localparam logic signed [PW-1:0] XMAX = PW'(64'sd2147483647);
  localparam logic signed [PW-1:0] XMIN = PW'(-64'sd2147483648);

  logic               v1, en1, en2;
  logic signed [PW-1:0] prod;
  logic [31:0]        gamma1;
  logic               degen1;
  logic signed [PW-1:0] shifted;
  logic signed [31:0] xte;
  cstate_t            data_next;

  assign en2 = !out_valid || out_ready;
  assign en1 = !v1 || en2;
  assign in_ready = en1;

  always_comb begin
    shifted = (prod + RND) >>> (GUARD_BITS + 20);
    if (shifted > XMAX) begin
      xte = 32'sh7FFF_FFFF;
    end else if (shifted < XMIN) begin
      xte = 32'sh8000_0000;
    end else begin
      xte = shifted[31:0];
    end
    data_next.x = CW'({lookahead, 8'h00});
    data_next.y = CW'($signed({xte, 8'h00}));
    data_next.u = '0;
    data_next.v = '0;
    data_next.z = '0;
    data_next.side.degenerate = degen1;
    data_next.side.gamma = gamma1;
    data_next.side.xte = xte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= in_valid;
      end
      if (en2) begin
        out_valid <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      prod   <= -(PW'(in_data.v) * PW'(INV_GAIN));
      gamma1 <= in_data.z;
      degen1 <= in_data.side.degenerate;
    end
    if (en2) begin
      out_data <= data_next;
    end
  end
endmodule

@@ hw/rtl/los_path_following_guidance_unit.sv @@
// Lookahead line-of-sight guidance: one guidance query in, one course result out.
// Throughput is one item per clock unless result.ready stalls the pipeline; every
// stage is a register with its own valid bit.
// rst is synchronous and active high: it empties the pipeline and sets the lookahead
// distance to 5.0 m. Depends on lpfg_pkg, lpfg_if, lpfg_front, lpfg_cordic, lpfg_gain.
module los_path_following_guidance_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [23:0]  cfg_data,
  lpfg_query_if.sink   query,
  lpfg_result_if.source result
);
  import lpfg_pkg::*;

  // The pipeline runs front stage, path-angle CORDIC, gain correction, steering
  // CORDIC, output register. Each stage loads whenever it is empty or its item moves
  // on, so bubbles close up and a full pipeline stalls without losing an item.

  logic [23:0] lookahead;

  logic    f_valid, f_ready;
  cstate_t f_data;
  logic    c1_valid, c1_ready;
  cstate_t c1_data;
  logic    g_valid, g_ready;
  cstate_t g_data;
  logic    c2_valid, c2_ready;
  cstate_t c2_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      lookahead <= LOOKAHEAD_RESET;
    end else if (cfg_we) begin
      lookahead <= cfg_data;
    end
  end

  // Segment direction and start-to-vessel offset.
  lpfg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .query     (query),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_data  (f_data)
  );

  // Vectoring the segment direction gives the path angle; the offset rotated along
  // with it ends in v as the gain-scaled, negated cross-track error.
  lpfg_cordic u_path_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_data),
    .out_valid (c1_valid),
    .out_ready (c1_ready),
    .out_data  (c1_data)
  );

  lpfg_gain u_gain (
    .clk       (clk),
    .rst       (rst),
    .lookahead (lookahead),
    .in_valid  (c1_valid),
    .in_ready  (c1_ready),
    .in_data   (c1_data),
    .out_valid (g_valid),
    .out_ready (g_ready),
    .out_data  (g_data)
  );

  // atan2(error, lookahead): the lookahead is never negative, so no quarter turn occurs.
  lpfg_cordic u_steer_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (g_valid),
    .in_ready  (g_ready),
    .in_data   (g_data),
    .out_valid (c2_valid),
    .out_ready (c2_ready),
    .out_data  (c2_data)
  );

  // Output register. A zero-length segment reports zeros with the flag set.
  assign c2_ready = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (c2_ready) begin
      result.valid <= c2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c2_ready) begin
      result.degenerate <= c2_data.side.degenerate;
      if (c2_data.side.degenerate) begin
        result.course_command    <= '0;
        result.path_angle        <= '0;
        result.cross_track_error <= '0;
      end else begin
        result.course_command    <= angle16(c2_data.side.gamma - c2_data.z);
        result.path_angle        <= angle16(c2_data.side.gamma);
        result.cross_track_error <= c2_data.side.xte;
      end
    end
  end
endmodule

@@ hw/rtl/lpfg_checker.sv @@
// Port-level checks for the guidance unit, attached to the top level by bind.
// Depends only on the top level's ports.
module lpfg_checker (
  input logic               clk,
  input logic               rst,
  input logic               q_valid,
  input logic               q_ready,
  input logic               r_valid,
  input logic               r_ready,
  input logic signed [15:0] r_course,
  input logic signed [15:0] r_path,
  input logic signed [31:0] r_xte,
  input logic               r_degen
);

  // An empty output register means the whole pipeline can move, so queries are taken.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !r_valid |-> q_ready)
    else $error("query refused while no result is pending");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !r_valid)
    else $error("result valid right after reset");

  a_degenerate_zero: assert property (@(posedge clk) disable iff (rst)
    (r_valid && r_degen) |-> (r_course == 16'sd0 && r_path == 16'sd0 && r_xte == 32'sd0))
    else $error("zero-length segment result carries nonzero fields");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (r_valid && !r_ready) |=> (r_valid && $stable(r_course) && $stable(r_path)
                               && $stable(r_xte) && $stable(r_degen)))
    else $error("stalled result changed");

endmodule

bind los_path_following_guidance_unit lpfg_checker u_lpfg_checker (
  .clk      (clk),
  .rst      (rst),
  .q_valid  (query.valid),
  .q_ready  (query.ready),
  .r_valid  (result.valid),
  .r_ready  (result.ready),
  .r_course (result.course_command),
  .r_path   (result.path_angle),
  .r_xte    (result.cross_track_error),
  .r_degen  (result.degenerate)
);

@@ test/tb_lpfg_ifs.sv @@
// Channel interfaces used by the guidance testbench (a copy is not needed: the RTL
// interfaces lpfg_query_if and lpfg_result_if are reused). This file holds a small
// package of testbench constants; it depends on lpfg_pkg.
package tb_lpfg_consts_pkg;
  timeunit 1ns;
  timeprecision 1ps;
  localparam int LATENCY_CYCLES = 2 * lpfg_pkg::NSTAGE + 6;
  localparam int WATCHDOG_LIMIT = 20000;
endpackage

@@ test/tb_los_path_following_guidance_unit.sv @@
// Self-checking testbench for los_path_following_guidance_unit: a table of directed
// guidance queries, then random queries, checked against a local predictor or hand-typed results.
// Depends on lpfg_pkg, lpfg_if (RTL) and tb_lpfg_consts_pkg.
module tb_los_path_following_guidance_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import lpfg_pkg::NSTAGE;
  import lpfg_pkg::LOOKAHEAD_RESET;
  import tb_lpfg_consts_pkg::*;

  typedef struct {
    logic signed [31:0] sx, sy, ex, ey, px, py;
  } query_t;

  typedef struct {
    logic signed [15:0] course;
    logic signed [15:0] path;
    logic signed [31:0] xte;
    logic               degen;
  } guidance_t;

  // One directed row: the query, and a hand-typed result where it is obvious.
  typedef struct {
    query_t    q;
    bit        typed;
    guidance_t res;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [23:0] cfg_data = '0;

  lpfg_query_if  query ();
  lpfg_result_if result ();

  los_path_following_guidance_unit dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .query    (query.sink),
    .result   (result.source)
  );

  always #5 clk = ~clk;

  // Predictor copy of the lookahead register.
  logic [23:0] lookahead_q = LOOKAHEAD_RESET;

  guidance_t expected_guidance[$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned queries_sent = 0;
  int unsigned degenerate_seen = 0;
  int unsigned idle_cycles = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  // Arctangent table for the predictor, in 32-bit binary angle units.
  function automatic logic [31:0] arctan_step(int i);
    logic [31:0] tab [0:31];
    tab = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
            32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
            32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
            32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
            32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
            32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
            32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
            32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000};
    return tab[i];
  endfunction

  // Vectoring rotation of (x,y) to the x axis, with (u,v) rotated alongside.
  // The >>> on 64-bit signed values floors, as the hardware shifts do.
  function automatic logic [31:0] rotate_to_axis(longint x, longint y,
                                                 ref longint u, ref longint v);
    logic [31:0] z;
    longint t, nx, ny, nu, nv;
    z = '0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 32'h4000_0000;
        t = u; u = v; v = -t;
      end else begin
        t = x; x = -y; y = t; z = 32'hC000_0000;
        t = u; u = -v; v = t;
      end
    end
    for (int i = 0; i < NSTAGE; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i); ny = y - (x >>> i);
        nu = u + (v >>> i); nv = v - (u >>> i);
        z = z + arctan_step(i);
      end else begin
        nx = x - (y >>> i); ny = y + (x >>> i);
        nu = u - (v >>> i); nv = v + (u >>> i);
        z = z - arctan_step(i);
      end
      x = nx; y = ny; u = nu; v = nv;
    end
    return z;
  endfunction

  function automatic logic [15:0] round_angle(logic [31:0] a);
    logic [31:0] r;
    r = a + 32'h0000_8000;
    return r[31:16];
  endfunction

  function automatic guidance_t predict_guidance(query_t q, logic [23:0] lookahead);
    guidance_t g;
    longint dx, dy, wx, wy, prod, e, du, dv;
    logic [31:0] gamma, psi;
    dx = longint'(q.ex) - longint'(q.sx);
    dy = longint'(q.ey) - longint'(q.sy);
    g = '{default: '0};
    if (dx == 0 && dy == 0) begin
      g.degen = 1'b1;
      return g;
    end
    wx = (longint'(q.sx) - longint'(q.px)) * 256;
    wy = (longint'(q.sy) - longint'(q.py)) * 256;
    du = 0;
    dv = 0;
    gamma = rotate_to_axis(dx * 256, dy * 256, wx, wy);
    // Remove the CORDIC gain and the guard bits, rounding half up, then saturate.
    prod = -(wy * 636751);
    e = (prod + (longint'(1) << 27)) >>> 28;
    if (e > 64'sd2147483647) e = 64'sd2147483647;
    if (e < -64'sd2147483648) e = -64'sd2147483648;
    psi = rotate_to_axis(longint'(lookahead) * 256, e * 256, du, dv);
    g.course = round_angle(gamma - psi);
    g.path = round_angle(gamma);
    g.xte = e[31:0];
    g.degen = 1'b0;
    return g;
  endfunction

  // Random coordinates: mostly local geometry, sometimes anywhere in the full range.
  function automatic logic signed [31:0] rand_coord(logic signed [31:0] near);
    case ($urandom_range(0, 9))
      0, 1: return $urandom;
      2: return near + $signed($urandom_range(0, 2) - 1);
      default: return near + $signed(32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000);
    endcase
  endfunction

  function automatic query_t random_query();
    query_t q;
    q.sx = rand_coord(32'sd0);
    q.sy = rand_coord(32'sd0);
    q.ex = rand_coord(q.sx);
    q.ey = rand_coord(q.sy);
    q.px = rand_coord(q.sx);
    q.py = rand_coord(q.sy);
    // A handful of zero-length segments keep the degenerate path exercised.
    if ($urandom_range(0, 49) == 0) begin
      q.ex = q.sx;
      q.ey = q.sy;
    end
    return q;
  endfunction

  // Receiver side: randomly idle on ready, check every accepted result.
  initial begin
    result.ready = 1'b0;
    forever begin
      @(negedge clk);
      result.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && result.valid && result.ready) begin
      guidance_t want;
      results_seen++;
      if (result.degenerate) degenerate_seen++;
      if (expected_guidance.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result course=%0d path=%0d xte=%0d degen=%0b",
                   result.course_command, result.path_angle,
                   result.cross_track_error, result.degenerate);
      end else begin
        want = expected_guidance.pop_front();
        if (result.course_command !== want.course || result.path_angle !== want.path ||
            result.cross_track_error !== want.xte || result.degenerate !== want.degen) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"ERROR: result %0d exp course=%0d path=%0d xte=%0d degen=%0b,",
                      " got %0d %0d %0d %0b"},
                     results_seen, want.course, want.path, want.xte, want.degen,
                     result.course_command, result.path_angle,
                     result.cross_track_error, result.degenerate);
        end
      end
    end
  end

  // Watchdog: cycles with no handshake on either channel.
  always @(posedge clk) begin
    if ((query.valid && query.ready) || (result.valid && result.ready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("ERROR: watchdog expired with %0d results outstanding",
               expected_guidance.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Offer one query, holding it until it is accepted. The expectation is queued at
  // the accepting edge so the checker never sees a result before its prediction.
  task automatic send_query(query_t q, bit typed, guidance_t typed_res);
    guidance_t want;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      query.valid <= 1'b0;
      @(negedge clk);
    end
    query.valid   <= 1'b1;
    query.start_x <= q.sx;
    query.start_y <= q.sy;
    query.end_x   <= q.ex;
    query.end_y   <= q.ey;
    query.pos_x   <= q.px;
    query.pos_y   <= q.py;
    want = typed ? typed_res : predict_guidance(q, lookahead_q);
    do @(posedge clk); while (!query.ready);
    expected_guidance.push_back(want);
    queries_sent++;
    @(negedge clk);
  endtask

  // Drain all outstanding results, then settle the pipeline before a register write.
  task automatic drain();
    query.valid <= 1'b0;
    while (expected_guidance.size() != 0) @(negedge clk);
    repeat (LATENCY_CYCLES + 4) @(negedge clk);
  endtask

  task automatic write_lookahead(logic [23:0] value);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we   <= 1'b0;
    lookahead_q = value;
  endtask

  task automatic run_random(int count);
    guidance_t none;
    none = '{default: '0};
    for (int i = 0; i < count; i++) begin
      send_query(random_query(), 1'b0, none);
      // Every so often stop and let the pipeline empty completely.
      if ($urandom_range(0, 199) == 0) drain();
    end
  endtask

  row_t directed [$];

  initial begin
    guidance_t zero_degen;
    guidance_t none;
    query_t q;
    none = '{default: '0};
    zero_degen = '{course: 16'sd0, path: 16'sd0, xte: 32'sd0, degen: 1'b1};

    query.valid   = 1'b0;
    query.start_x = '0;
    query.start_y = '0;
    query.end_x   = '0;
    query.end_y   = '0;
    query.pos_x   = '0;
    query.pos_y   = '0;

    // Zero-length segments: flag set, everything else zero.
    directed.push_back('{'{0, 0, 0, 0, 0, 0}, 1'b1, zero_degen});
    directed.push_back('{'{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                           32'h80000000, 32'h7FFFFFFF}, 1'b1, zero_degen});
    directed.push_back('{'{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                           32'h12345678, 32'hFFFFFFFF}, 1'b1, zero_degen});
    // Vessel on a path along +x: heading zero, no cross-track error.
    directed.push_back('{'{0, 0, 32'sd4096, 0, 0, 0}, 1'b1,
                         '{course: 16'sd0, path: 16'sd0, xte: 32'sd0, degen: 1'b0}});
    // The four axis directions, and the quadrant fix-ups for negative x.
    directed.push_back('{'{0, 0, 0, 32'sd4096, 0, 0}, 1'b0, none});
    directed.push_back('{'{0, 0, -32'sd4096, 0, 0, 0}, 1'b0, none});
    directed.push_back('{'{0, 0, -32'sd4096, 32'sd1, 0, 0}, 1'b0, none});
    directed.push_back('{'{0, 0, -32'sd4096, -32'sd1, 0, 0}, 1'b0, none});
    directed.push_back('{'{0, 0, 0, -32'sd4096, 0, 0}, 1'b0, none});
    // Off-track on either side, and beyond either end of the segment.
    directed.push_back('{'{0, 0, 32'sd40960, 0, 32'sd20480, 32'sd8192}, 1'b0, none});
    directed.push_back('{'{0, 0, 32'sd40960, 0, 32'sd20480, -32'sd8192}, 1'b0, none});
    directed.push_back('{'{0, 0, 32'sd40960, 0, -32'sd90000, 32'sd4096}, 1'b0, none});
    directed.push_back('{'{0, 0, 32'sd40960, 0, 32'sd900000, -32'sd4096}, 1'b0, none});
    // Extremes: full-range segments and positions, saturating the cross-track error.
    directed.push_back('{'{32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                           32'h7FFFFFFF, 32'h7FFFFFFF}, 1'b0, none});
    directed.push_back('{'{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                           32'h80000000, 32'h80000000}, 1'b0, none});
    directed.push_back('{'{32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                           32'h80000000, 32'h80000000}, 1'b0, none});
    directed.push_back('{'{32'hFFFFFFFF, 32'hFFFFFFFF, 32'h00000000, 32'h00000000,
                           32'h55555555, 32'hAAAAAAAA}, 1'b0, none});
    directed.push_back('{'{32'hAAAAAAAA, 32'h55555555, 32'h55555555, 32'hAAAAAAAA,
                           32'hFFFFFFFF, 32'h00000001}, 1'b0, none});
    // Tiny segment: one least significant bit long.
    directed.push_back('{'{0, 0, 1, 0, 0, 32'sd4096}, 1'b0, none});

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Phase 1: directed table, then random queries, at the reset lookahead, sender idling 30%, receiver 78%.
    send_idle_pct = 30;
    recv_idle_pct = 78;
    foreach (directed[i])
      send_query(directed[i].q, directed[i].typed, directed[i].res);
    run_random(550);

    // Phase 2: smallest lookahead, where the steering angle is at its steepest.
    write_lookahead(24'd1);
    send_idle_pct = 78;
    recv_idle_pct = 30;
    foreach (directed[i])
      if (!directed[i].typed) send_query(directed[i].q, 1'b0, none);
    run_random(550);

    // Phase 3: largest lookahead, then a mid value, with neither side idling.
    write_lookahead(24'hFFFFFF);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(300);
    write_lookahead(24'h5A5A5A);
    run_random(300);

    // Back to the reset value so every bit of the register has toggled both ways.
    write_lookahead(LOOKAHEAD_RESET);
    q = '{0, 0, 32'sd4096, 0, 0, 0};
    send_query(q, 1'b1, '{course: 16'sd0, path: 16'sd0, xte: 32'sd0, degen: 1'b0});

    query.valid <= 1'b0;
    while (expected_guidance.size() != 0) @(negedge clk);
    repeat (LATENCY_CYCLES + 4) @(negedge clk);

    $display("Covered %0d queries (%0d zero-length) over four lookahead settings,",
             queries_sent, degenerate_seen);
    $display("with idling on either side and back-to-back traffic; %0d results checked.",
             results_seen);
    if (mismatches == 0 && expected_guidance.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ los_path_following_guidance_unit.f @@
hw/rtl/lpfg_pkg.sv
hw/rtl/lpfg_if.sv
hw/rtl/lpfg_front.sv
hw/rtl/lpfg_cordic.sv
hw/rtl/lpfg_gain.sv
hw/rtl/los_path_following_guidance_unit.sv
hw/rtl/lpfg_checker.sv
test/tb_lpfg_ifs.sv
test/tb_los_path_following_guidance_unit.sv
